// File: sv/mmad_pkg.sv
// ----------------------------------------------------------------------------
// mmad_pkg
// Shared widths, reset values, register codes and types of the median/mean
// apogee detector.
// ----------------------------------------------------------------------------
package mmad_pkg;

    localparam int ALT_W   = 24;
    localparam int ACC_W   = 16;
    localparam int VEL_W   = 48;
    localparam int THR_W   = 4;
    localparam int GAIN_W  = 16;
    localparam int VOTE_W  = 4;
    localparam int CFG_A_W = 1;

    localparam int SAMPLES_PER_POINT = 9;
    localparam int CHAIN_CELLS       = SAMPLES_PER_POINT - 1;
    localparam int CNT_W             = $clog2(SAMPLES_PER_POINT);

    localparam int POINTS_PER_WINDOW_DEF = 10;

    localparam logic [THR_W-1:0]  THR_RESET  = 4'd7;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd10000;
    localparam logic [VOTE_W-1:0] VOTE_MAX   = 4'd15;

    typedef enum logic [CFG_A_W-1:0] {
        REG_THRESHOLD = 1'b0,
        REG_GAIN      = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ALT_W-1:0] alt;
        logic signed [ACC_W-1:0] acc;
    } sample_t;

    typedef struct packed {
        logic sum_en;
        logic prod_en;
        logic quot_en;
    } filt_en_t;

endpackage

// File: sv/mmad_if.sv
// ----------------------------------------------------------------------------
// mmad_if
// Request channels of the apogee detector: raw sample pairs in, filtered
// points with vote status out.
// ----------------------------------------------------------------------------
interface mmad_in_if import mmad_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [ALT_W-1:0] altitude_sample;
    logic signed [ACC_W-1:0] accel_sample;

    modport source (output valid, output altitude_sample, output accel_sample,
                    input ready);
    modport sink   (input valid, input altitude_sample, input accel_sample,
                    output ready);

endinterface

interface mmad_out_if import mmad_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [ALT_W-1:0]  filtered_altitude;
    logic signed [ACC_W-1:0]  filtered_accel;
    logic signed [VEL_W-1:0]  velocity;
    logic                     window_done;
    logic                     deploy;
    logic        [VOTE_W-1:0] descent_votes;
    logic        [VOTE_W-1:0] negative_votes;

    modport source (output valid, output filtered_altitude, output filtered_accel,
                    output velocity, output window_done, output deploy,
                    output descent_votes, output negative_votes, input ready);
    modport sink   (input valid, input filtered_altitude, input filtered_accel,
                    input velocity, input window_done, input deploy,
                    input descent_votes, input negative_votes, output ready);

endinterface

// File: sv/median_mean_apogee_detector.sv
// A point enters the pipeline on the edge that takes its ninth sample.
// Throughput: one sample per cycle while ready is high; one point per nine samples.
// Points run through a five-stage elastic pipeline (median sum, reciprocal
// multiply, quotient, gain multiply, velocity and votes); ready drops only on
// a ninth sample while that pipeline is full and stalled.
// Reset clears counters, velocity and votes, and loads threshold 7, gain 10000.
// ----------------------------------------------------------------------------
// median_mean_apogee_detector
// Sample chain, median/mean filters, saturating velocity integral and windowed
// descent voting.
// ----------------------------------------------------------------------------
module median_mean_apogee_detector import mmad_pkg::*;
#(
    parameter int POINTS_PER_WINDOW = POINTS_PER_WINDOW_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wen,
    input  logic [CFG_A_W-1:0]  cfg_addr,
    input  logic [GAIN_W-1:0]   cfg_wdata,
    mmad_in_if.sink             samples,
    mmad_out_if.source          points
);

    localparam int PIDX_W   = $clog2(POINTS_PER_WINDOW);
    localparam int STAGES   = 5;
    localparam int AREA_PW  = 2 * (ACC_W + 1);
    localparam logic [CNT_W-1:0]  LAST_SAMPLE = CNT_W'(SAMPLES_PER_POINT - 1);
    localparam logic [PIDX_W-1:0] LAST_POINT  = PIDX_W'(POINTS_PER_WINDOW - 1);
    localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

    logic [THR_W-1:0]  thr_reg;
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                REG_GAIN:      gain_reg <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // pipeline control
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] rdy;
    logic [STAGES-1:0] load;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              in_acc;
    logic              last_sample;

    assign last_sample   = (cnt_reg == LAST_SAMPLE);
    assign samples.ready = !last_sample || rdy[0];
    assign in_acc        = samples.valid && samples.ready;

    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || points.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        load[0] = in_acc && last_sample;
        for (int k = 1; k < STAGES; k++)
        begin
            load[k] = vld_reg[k-1] && rdy[k];
        end
        for (int k = 0; k < STAGES; k++)
        begin
            vld_next[k] = load[k] || (vld_reg[k] && !rdy[k]);
        end
        cnt_next = cnt_reg;
        if (in_acc)
        begin
            cnt_next = last_sample ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            cnt_reg <= cnt_next;
        end
    end

    // sample chain
    sample_t cell_q [CHAIN_CELLS];
    sample_t head;

    assign head.alt = samples.altitude_sample;
    assign head.acc = samples.accel_sample;

    genvar gi;
    generate
        for (gi = 0; gi < CHAIN_CELLS; gi++)
        begin : g_chain
            mmad_cell u_cell (
                .clk   (clk),
                .shift (in_acc),
                .d     ((gi == 0) ? head : cell_q[(gi == 0) ? 0 : gi - 1]),
                .q     (cell_q[gi])
            );
        end
    endgenerate

    logic signed [ALT_W-1:0] alt_taps [SAMPLES_PER_POINT];
    logic signed [ACC_W-1:0] acc_taps [SAMPLES_PER_POINT];

    always_comb
    begin
        alt_taps[0] = head.alt;
        acc_taps[0] = head.acc;
        for (int k = 0; k < CHAIN_CELLS; k++)
        begin
            alt_taps[k+1] = cell_q[k].alt;
            acc_taps[k+1] = cell_q[k].acc;
        end
    end

    filt_en_t                filt_en;
    logic signed [ALT_W-1:0] falt;
    logic signed [ACC_W-1:0] facc;

    assign filt_en.sum_en  = load[0];
    assign filt_en.prod_en = load[1];
    assign filt_en.quot_en = load[2];

    mmad_filter #(.W(ALT_W)) u_alt_filter (
        .clk  (clk),
        .en   (filt_en),
        .taps (alt_taps),
        .mean (falt)
    );

    mmad_filter #(.W(ACC_W)) u_acc_filter (
        .clk  (clk),
        .en   (filt_en),
        .taps (acc_taps),
        .mean (facc)
    );

    // gain multiply
    logic signed [ACC_W:0]     pair_sum;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [AREA_PW-1:0] gprod_next;
    logic signed [AREA_PW-1:0] gprod_reg;
    logic signed [ALT_W-1:0]   falt4_reg;
    logic signed [ACC_W-1:0]   facc4_reg;
    logic signed [ACC_W-1:0]   prev_facc_reg;

    always_comb
    begin
        pair_sum   = {facc[ACC_W-1], facc} + {prev_facc_reg[ACC_W-1], prev_facc_reg};
        gain_s     = $signed({1'b0, gain_reg});
        gprod_next = AREA_PW'(pair_sum) * AREA_PW'(gain_s);
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            gprod_reg <= gprod_next;
            falt4_reg <= falt;
            facc4_reg <= facc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_facc_reg <= '0;
        end
        else if (load[3])
        begin
            prev_facc_reg <= facc;
        end
    end

    // velocity and votes
    logic signed [AREA_PW-1:0] area_rnd;
    logic signed [AREA_PW-1:0] area;
    logic signed [VEL_W:0]     vsum;
    logic signed [VEL_W-1:0]   vel_next;
    logic signed [VEL_W-1:0]   vel_reg;
    logic signed [ALT_W-1:0]   prev_falt_reg;
    logic [PIDX_W-1:0]         pidx_reg;
    logic [PIDX_W-1:0]         pidx_next;
    logic [VOTE_W-1:0]         desc_reg;
    logic [VOTE_W-1:0]         neg_reg;
    logic [VOTE_W-1:0]         desc_vote;
    logic [VOTE_W-1:0]         neg_vote;
    logic [VOTE_W-1:0]         desc_next;
    logic [VOTE_W-1:0]         neg_next;
    logic                      done;
    logic                      deploy_next;

    always_comb
    begin
        area_rnd = gprod_reg + $signed({{(AREA_PW-1){1'b0}}, gprod_reg[AREA_PW-1]});
        area     = area_rnd >>> 1;
        vsum     = {vel_reg[VEL_W-1], vel_reg} + (VEL_W+1)'(area);
        if (vsum[VEL_W] != vsum[VEL_W-1])
        begin
            vel_next = vsum[VEL_W] ? VEL_MIN : VEL_MAX;
        end
        else
        begin
            vel_next = vsum[VEL_W-1:0];
        end
    end

    always_comb
    begin
        desc_vote = desc_reg;
        neg_vote  = neg_reg;
        if (pidx_reg != '0)
        begin
            if ((prev_falt_reg > falt4_reg) && (desc_reg < VOTE_MAX))
            begin
                desc_vote = desc_reg + VOTE_W'(1);
            end
            if (vel_next[VEL_W-1] && (neg_reg < VOTE_MAX))
            begin
                neg_vote = neg_reg + VOTE_W'(1);
            end
        end
        done        = (pidx_reg == LAST_POINT);
        deploy_next = done && (desc_vote >= thr_reg) && (neg_vote >= thr_reg);
        pidx_next   = done ? '0 : pidx_reg + PIDX_W'(1);
        desc_next   = done ? '0 : desc_vote;
        neg_next    = done ? '0 : neg_vote;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg  <= '0;
            pidx_reg <= '0;
            desc_reg <= '0;
            neg_reg  <= '0;
        end
        else if (load[4])
        begin
            vel_reg  <= vel_next;
            pidx_reg <= pidx_next;
            desc_reg <= desc_next;
            neg_reg  <= neg_next;
        end
    end

    logic signed [ALT_W-1:0] o_falt_reg;
    logic signed [ACC_W-1:0] o_facc_reg;
    logic signed [VEL_W-1:0] o_vel_reg;
    logic                    o_done_reg;
    logic                    o_deploy_reg;
    logic [VOTE_W-1:0]       o_desc_reg;
    logic [VOTE_W-1:0]       o_neg_reg;

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            prev_falt_reg <= falt4_reg;
            o_falt_reg    <= falt4_reg;
            o_facc_reg    <= facc4_reg;
            o_vel_reg     <= vel_next;
            o_done_reg    <= done;
            o_deploy_reg  <= deploy_next;
            o_desc_reg    <= desc_vote;
            o_neg_reg     <= neg_vote;
        end
    end

    assign points.valid             = vld_reg[STAGES-1];
    assign points.filtered_altitude = o_falt_reg;
    assign points.filtered_accel    = o_facc_reg;
    assign points.velocity          = o_vel_reg;
    assign points.window_done       = o_done_reg;
    assign points.deploy            = o_deploy_reg;
    assign points.descent_votes     = o_desc_reg;
    assign points.negative_votes    = o_neg_reg;

    a_deploy_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        points.valid && points.deploy |-> points.window_done)
        else $error("deploy outside window end");

    a_stall_on_point: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> (cnt_reg == LAST_SAMPLE) && vld_reg[0] && !rdy[0])
        else $error("input stalled without a blocked point");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LAST_SAMPLE)
        else $error("sample counter out of range");

    a_pidx_range: assert property (@(posedge clk) disable iff (!rst_n)
        pidx_reg <= LAST_POINT)
        else $error("point index out of range");

endmodule

// File: sv/mmad_cell.sv
// ----------------------------------------------------------------------------
// mmad_cell
// One cell of the sample chain: holds an altitude/acceleration pair and
// passes it to the next cell on every accepted request.
// ----------------------------------------------------------------------------
module mmad_cell import mmad_pkg::*;
(
    input  logic    clk,
    input  logic    shift,
    input  sample_t d,
    output sample_t q
);

    sample_t data_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            data_reg <= d;
        end
    end

    assign q = data_reg;

endmodule

// File: sv/mmad_filter.sv
// ----------------------------------------------------------------------------
// mmad_filter
// Median-of-triples then mean-of-three filter for one channel, three stages:
// median sum, reciprocal multiply, signed quotient.
// ----------------------------------------------------------------------------
module mmad_filter import mmad_pkg::*;
#(
    parameter int W = ALT_W
)
(
    input  logic                clk,
    input  filt_en_t            en,
    input  logic signed [W-1:0] taps [SAMPLES_PER_POINT],
    output logic signed [W-1:0] mean
);

    localparam int SW = W + 2;
    localparam int MW = W + 1;
    localparam int N  = W + 3;
    localparam int RW = N - 1;
    localparam int PW = MW + RW;
    localparam logic [RW-1:0] RECIP = RW'(((64'd1 << N) + 64'd2) / 64'd3);

    function automatic logic signed [W-1:0] med3(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b,
                                                 input logic signed [W-1:0] c);
        logic signed [W-1:0] lo;
        logic signed [W-1:0] hi;
        logic signed [W-1:0] mid;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        mid = (hi < c) ? hi : c;
        return (lo > mid) ? lo : mid;
    endfunction

    function automatic logic signed [SW-1:0] sx(input logic signed [W-1:0] v);
        return {{2{v[W-1]}}, v};
    endfunction

    logic signed [SW-1:0] sum_reg;
    logic signed [SW-1:0] sum_next;
    logic        [SW-1:0] mag_full;
    logic        [MW-1:0] mag;
    logic        [PW-1:0] prod_reg;
    logic        [PW-1:0] prod_next;
    logic                 neg_reg;
    logic        [W-1:0]  quo;
    logic signed [W-1:0]  mean_reg;
    logic signed [W-1:0]  mean_next;

    always_comb
    begin
        sum_next = sx(med3(taps[0], taps[1], taps[2]))
                 + sx(med3(taps[3], taps[4], taps[5]))
                 + sx(med3(taps[6], taps[7], taps[8]));
    end

    always_comb
    begin
        mag_full  = sum_reg[SW-1] ? (~sum_reg + SW'(1)) : sum_reg;
        mag       = mag_full[MW-1:0];
        prod_next = PW'(mag) * PW'(RECIP);
    end

    always_comb
    begin
        quo       = prod_reg[PW-1:N];
        mean_next = neg_reg ? $signed(~quo + W'(1)) : $signed(quo);
    end

    always_ff @(posedge clk)
    begin
        if (en.sum_en)
        begin
            sum_reg <= sum_next;
        end
        if (en.prod_en)
        begin
            prod_reg <= prod_next;
            neg_reg  <= sum_reg[SW-1];
        end
        if (en.quot_en)
        begin
            mean_reg <= mean_next;
        end
    end

    assign mean = mean_reg;

endmodule
